FILE: design/scfb_pkg.sv
// ----------------------------------------------------------------------------
// scfb_pkg
// Shared types, constants and helper functions for the scaled command frame
// builder: payload structs, register map, frame layout and CRC-8 step.
// ----------------------------------------------------------------------------
package scfb_pkg;

   // frame layout
   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam int         FRAME_LEN = 6;

   localparam logic [2:0] POS_FLAG_OPEN  = 3'd0;
   localparam logic [2:0] POS_SERVO      = 3'd1;
   localparam logic [2:0] POS_STEP       = 3'd2;
   localparam logic [2:0] POS_BUTTON     = 3'd3;
   localparam logic [2:0] POS_CRC        = 3'd4;
   localparam logic [2:0] POS_FLAG_CLOSE = 3'd5;

   // crc-8, poly 0x31, init 0xff, msb first
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   // queue between front pipeline and serialiser
   localparam int QUEUE_DEPTH = 2;

   // register map
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_SERVO_GAIN   = 2'd0,
      REG_SERVO_OFFSET = 2'd1,
      REG_STEP_GAIN    = 2'd2,
      REG_STEP_OFFSET  = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [15:0] servo_value;
      logic [15:0] step_value;
      logic [7:0]  button_state;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic [2:0] byte_index;
      logic       last_byte;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] servo_gain;
      logic signed [31:0] servo_offset;
      logic signed [31:0] step_gain;
      logic signed [31:0] step_offset;
   } csr_regs_type;

   // the variable bytes of one frame, flags are added on the way out
   typedef struct packed {
      logic [7:0] servo_byte;
      logic [7:0] step_byte;
      logic [7:0] button_state;
      logic [7:0] crc;
   } frame_type;

   typedef struct packed {
      logic not_full;
      logic not_empty;
   } queue_status_type;

   // eight shift steps of the crc register, message byte already folded in
   function automatic logic [7:0] crc8_shift(input logic [7:0] value);
      logic [7:0] crc;
      crc = value;
      for (int b = 0; b < 8; b++) begin
         if (crc[7]) begin
            crc = {crc[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            crc = {crc[6:0], 1'b0};
         end
      end
      return crc;
   endfunction

   // crc state once the opening flag has gone through
   localparam logic [7:0] CRC_AFTER_FLAG = crc8_shift(CRC_INIT ^ FLAG_BYTE);

   // truncate q16.16 sum toward zero and clamp to 0..255
   function automatic logic [7:0] sat_byte(input logic signed [48:0] sum);
      logic [7:0] result;
      if (sum[48]) begin
         result = 8'd0;
      end else if (|sum[47:24]) begin
         result = 8'hFF;
      end else begin
         result = sum[23:16];
      end
      return result;
   endfunction

endpackage

FILE: design/scfb_csr.sv
// ----------------------------------------------------------------------------
// scfb_csr
// APB-style register block holding the signed Q16.16 gains and offsets.
// ----------------------------------------------------------------------------
module scfb_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [scfb_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [scfb_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [scfb_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output scfb_pkg::csr_regs_type              regs
);
   import scfb_pkg::*;

   csr_regs_type  regs_ff;
   csr_regs_type  regs_in;
   reg_index_type index;
   logic          write_en;

   // word index, byte lanes ignored
   assign index    = reg_index_type'(csr_paddr[3:2]);
   assign write_en = csr_psel && csr_penable && csr_pwrite;

   // register write decode
   always_comb begin
      regs_in = regs_ff;
      if (write_en) begin
         unique case (index)
            REG_SERVO_GAIN:   regs_in.servo_gain   = csr_pwdata;
            REG_SERVO_OFFSET: regs_in.servo_offset = csr_pwdata;
            REG_STEP_GAIN:    regs_in.step_gain    = csr_pwdata;
            REG_STEP_OFFSET:  regs_in.step_offset  = csr_pwdata;
            default:          regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.servo_gain   <= 32'sh0001_0000;
         regs_ff.servo_offset <= '0;
         regs_ff.step_gain    <= 32'sh0001_0000;
         regs_ff.step_offset  <= '0;
      end else begin
         regs_ff <= regs_in;
      end
   end

   // read mux
   always_comb begin
      unique case (index)
         REG_SERVO_GAIN:   csr_prdata = regs_ff.servo_gain;
         REG_SERVO_OFFSET: csr_prdata = regs_ff.servo_offset;
         REG_STEP_GAIN:    csr_prdata = regs_ff.step_gain;
         REG_STEP_OFFSET:  csr_prdata = regs_ff.step_offset;
         default:          csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign regs       = regs_ff;

endmodule

FILE: design/scfb_front.sv
// ----------------------------------------------------------------------------
// scfb_front
// Front pipeline: takes a command, scales both values to bytes and works out
// the CRC-8 one byte per stage, then pushes the finished frame to the queue.
// ----------------------------------------------------------------------------
module scfb_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  scfb_pkg::req_type          req_payload,
   input  scfb_pkg::csr_regs_type     regs,
   input  scfb_pkg::queue_status_type queue_status,
   output logic                       push,
   output scfb_pkg::frame_type        push_frame
);
   import scfb_pkg::*;

   // stage 1: captured command
   logic                v1_ff;
   req_type             cmd_ff;
   // stage 2: products
   logic                v2_ff;
   logic signed [48:0]  servo_prod_ff, servo_prod_in;
   logic signed [48:0]  step_prod_ff, step_prod_in;
   logic [7:0]          button2_ff;
   // stage 3: scaled bytes
   logic                v3_ff;
   frame_type           f3_ff, f3_in;
   // stages 4 to 6: crc, one message byte a stage
   logic                v4_ff, v5_ff, v6_ff;
   frame_type           f4_ff, f4_in;
   frame_type           f5_ff, f5_in;
   frame_type           f6_ff, f6_in;
   logic                advance;

   // whole pipeline moves together unless the last stage is blocked
   assign advance   = !v6_ff || queue_status.not_full;
   assign req_ready = advance;
   assign push      = v6_ff && queue_status.not_full;
   assign push_frame = f6_ff;

   // signed gain times unsigned value
   assign servo_prod_in = $signed(regs.servo_gain) * $signed({1'b0, cmd_ff.servo_value});
   assign step_prod_in  = $signed(regs.step_gain) * $signed({1'b0, cmd_ff.step_value});

   // add offsets and clamp
   always_comb begin
      f3_in              = '0;
      f3_in.servo_byte   = sat_byte(servo_prod_ff + 49'(regs.servo_offset));
      f3_in.step_byte    = sat_byte(step_prod_ff + 49'(regs.step_offset));
      f3_in.button_state = button2_ff;
   end

   // crc through servo byte, step byte folded in
   always_comb begin
      f4_in     = f3_ff;
      f4_in.crc = crc8_shift(CRC_AFTER_FLAG ^ f3_ff.servo_byte) ^ f3_ff.step_byte;
   end

   // crc through step byte, button byte folded in
   always_comb begin
      f5_in     = f4_ff;
      f5_in.crc = crc8_shift(f4_ff.crc) ^ f4_ff.button_state;
   end

   // crc through button byte
   always_comb begin
      f6_in     = f5_ff;
      f6_in.crc = crc8_shift(f5_ff.crc);
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (advance) begin
         cmd_ff        <= req_payload;
         servo_prod_ff <= servo_prod_in;
         step_prod_ff  <= step_prod_in;
         button2_ff    <= cmd_ff.button_state;
         f3_ff         <= f3_in;
         f4_ff         <= f4_in;
         f5_ff         <= f5_in;
         f6_ff         <= f6_in;
      end
   end

endmodule

FILE: design/scfb_queue.sv
// ----------------------------------------------------------------------------
// scfb_queue
// Short frame queue between the front pipeline and the serialiser.
// ----------------------------------------------------------------------------
module scfb_queue #(
   parameter int DEPTH = scfb_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  scfb_pkg::frame_type        push_frame,
   input  logic                       pop,
   output scfb_pkg::frame_type        head_frame,
   output scfb_pkg::queue_status_type status
);
   import scfb_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   frame_type        store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // frame storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_frame;
      end
   end

   assign head_frame       = store_ff[rd_ptr_ff];
   assign status.not_full  = (count_ff != FULL_CNT);
   assign status.not_empty = (count_ff != '0);

endmodule

FILE: design/scfb_back.sv
// ----------------------------------------------------------------------------
// scfb_back
// Serialiser: sends the head frame of the queue one byte per transaction,
// flags around it, through a registered output stage.
// ----------------------------------------------------------------------------
module scfb_back (
   input  logic                       clock,
   input  logic                       reset,
   input  scfb_pkg::frame_type        head_frame,
   input  scfb_pkg::queue_status_type queue_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output scfb_pkg::rsp_type          rsp_payload
);
   import scfb_pkg::*;

   logic       rsp_valid_ff;
   rsp_type    rsp_ff, rsp_in;
   logic [2:0] index_ff, index_in;
   logic       load;
   logic       emit;
   logic       at_last;

   assign load    = !rsp_valid_ff || rsp_ready;
   assign emit    = load && queue_status.not_empty;
   assign at_last = (index_ff == POS_FLAG_CLOSE);
   assign pop     = emit && at_last;

   // byte select for the current position
   always_comb begin
      rsp_in            = '0;
      rsp_in.byte_index = index_ff;
      rsp_in.last_byte  = at_last;
      unique case (index_ff)
         POS_FLAG_OPEN:  rsp_in.frame_byte = FLAG_BYTE;
         POS_SERVO:      rsp_in.frame_byte = head_frame.servo_byte;
         POS_STEP:       rsp_in.frame_byte = head_frame.step_byte;
         POS_BUTTON:     rsp_in.frame_byte = head_frame.button_state;
         POS_CRC:        rsp_in.frame_byte = head_frame.crc;
         POS_FLAG_CLOSE: rsp_in.frame_byte = FLAG_BYTE;
         default:        rsp_in.frame_byte = FLAG_BYTE;
      endcase
   end

   // byte position counter
   always_comb begin
      index_in = index_ff;
      if (emit) begin
         index_in = at_last ? POS_FLAG_OPEN : index_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         index_ff     <= POS_FLAG_OPEN;
      end else begin
         index_ff <= index_in;
         if (load) begin
            rsp_valid_ff <= queue_status.not_empty;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: design/scaled_command_frame_builder.sv
// ----------------------------------------------------------------------------
// scaled_command_frame_builder
// Builds a six-byte command frame (flag, scaled servo, scaled step, buttons,
// crc-8, flag) from each command and sends it one byte per transaction.
// ----------------------------------------------------------------------------
// path: a command passes the capture register, five more pipeline stages,
// the queue storage and the output register before its first byte is on rsp
// throughput: one frame byte per cycle while rsp_ready is high and a frame is
// queued, set by the serialiser sending a single byte a cycle; the front
// pipeline accepts commands while earlier frames go out, until the queue fills
// reset: gains to 1.0, offsets to 0, pipeline, queue and output emptied at once
module scaled_command_frame_builder #(
   parameter int QUEUE_DEPTH = scfb_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  scfb_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output scfb_pkg::rsp_type               rsp_payload,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [scfb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [scfb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [scfb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import scfb_pkg::*;

   csr_regs_type     regs;
   queue_status_type queue_status;
   frame_type        push_frame;
   frame_type        head_frame;
   logic             push;
   logic             pop;

   // configuration registers
   scfb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .regs        (regs)
   );

   // scaling and crc pipeline
   scfb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .regs         (regs),
      .queue_status (queue_status),
      .push         (push),
      .push_frame   (push_frame)
   );

   // frame queue
   scfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .pop        (pop),
      .head_frame (head_frame),
      .status     (queue_status)
   );

   // byte serialiser
   scfb_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_frame   (head_frame),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload)
   );

   // queue is never written while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> queue_status.not_full)
      else $error("frame pushed into a full queue");

   // a frame is only retired from an occupied queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> queue_status.not_empty)
      else $error("frame popped from an empty queue");

   // closing flag marker and position agree
   a_last_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.last_byte == (rsp_payload.byte_index == POS_FLAG_CLOSE)))
      else $error("last byte marker out of step with byte position");

   // a byte after the closing flag opens the next frame
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_payload.last_byte) ##1 rsp_valid
      |-> (rsp_payload.byte_index == POS_FLAG_OPEN) && (rsp_payload.frame_byte == FLAG_BYTE))
      else $error("frame did not restart at the opening flag");

endmodule

FILE: tb/sv/tb_scaled_command_frame_builder.sv
// ----------------------------------------------------------------------------
// tb_scaled_command_frame_builder
// Self-checking bench for the command frame builder. Commands are driven on
// the req channel and every frame byte on the rsp channel is checked against
// a local prediction of the six-byte frame. Gains and offsets are changed
// between phases over the csr port and read back.
// ----------------------------------------------------------------------------
module tb_scaled_command_frame_builder;
   timeunit 1ns;
   timeprecision 1ps;

   import scfb_pkg::*;

   // frame constants, kept local to the bench
   localparam logic [7:0] FRAME_FLAG = 8'h7E;
   localparam logic [7:0] CRC_SEED   = 8'hFF;
   localparam logic [7:0] CRC_GEN    = 8'h31;
   localparam int         FRAME_BYTES = 6;
   localparam longint     Q_ONE       = 65536;

   localparam int IDLE_PCT      = 26;
   localparam int HOLD_CYCLES   = 250;
   localparam int DRAIN_CYCLES  = 16;
   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_PHASES = 4;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // commands waiting to be sent and frame bytes still to arrive
   req_type     cmd_backlog[$];
   rsp_type     frame_bytes_due[$];
   // local copy of the gain and offset registers
   logic [31:0] csr_shadow [4] = '{32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0};

   int          send_idle_pct = IDLE_PCT;
   int          recv_idle_pct = IDLE_PCT;
   logic        hold_request = 1'b0;
   int          hold_left = 0;
   int          quiet_cycles = 0;
   int          error_count = 0;

   scaled_command_frame_builder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------

   // q16.16 gain times value plus offset, truncated and clamped to a byte
   function automatic logic [7:0] scale_byte(input logic [31:0] gain, input logic [31:0] offset,
                                             input logic [15:0] value);
      longint exact_sum;
      longint whole;
      exact_sum = longint'($signed(gain)) * longint'(value) + longint'($signed(offset));
      if (exact_sum < 0) begin
         return 8'd0;
      end
      whole = exact_sum / Q_ONE;
      if (whole > 255) begin
         return 8'hFF;
      end
      return whole[7:0];
   endfunction

   // crc-8 over the four header bytes, first byte in the top bits
   function automatic logic [7:0] header_crc(input logic [31:0] header);
      logic [7:0] crc;
      crc = CRC_SEED;
      for (int k = 3; k >= 0; k--) begin
         crc ^= header[8*k +: 8];
         for (int b = 0; b < 8; b++) begin
            crc = crc[7] ? ((crc << 1) ^ CRC_GEN) : (crc << 1);
         end
      end
      return crc;
   endfunction

   // queue the six bytes that one command turns into
   task automatic predict_frame(input req_type cmd);
      logic [7:0] frame [FRAME_BYTES];
      rsp_type    due;
      frame[0] = FRAME_FLAG;
      frame[1] = scale_byte(csr_shadow[REG_SERVO_GAIN], csr_shadow[REG_SERVO_OFFSET],
                            cmd.servo_value);
      frame[2] = scale_byte(csr_shadow[REG_STEP_GAIN], csr_shadow[REG_STEP_OFFSET],
                            cmd.step_value);
      frame[3] = cmd.button_state;
      frame[4] = header_crc({frame[0], frame[1], frame[2], frame[3]});
      frame[5] = FRAME_FLAG;
      for (int k = 0; k < FRAME_BYTES; k++) begin
         due.frame_byte = frame[k];
         due.byte_index = 3'(k);
         due.last_byte  = (k == FRAME_BYTES - 1);
         frame_bytes_due.push_back(due);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("%0t mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   // ------------------------------------------------------------------------
   // req driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            predict_frame(req_payload);
         end
         if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_payload <= cmd_backlog.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // rsp monitor and checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (frame_bytes_due.size() == 0) begin
               report_mismatch("frame byte with nothing outstanding", 32'(rsp_payload), '0);
            end else begin
               want = frame_bytes_due.pop_front();
               if (rsp_payload.frame_byte !== want.frame_byte) begin
                  report_mismatch("frame_byte", 32'(rsp_payload.frame_byte),
                                  32'(want.frame_byte));
               end
               if (rsp_payload.byte_index !== want.byte_index) begin
                  report_mismatch("byte_index", 32'(rsp_payload.byte_index),
                                  32'(want.byte_index));
               end
               if (rsp_payload.last_byte !== want.last_byte) begin
                  report_mismatch("last_byte", 32'(rsp_payload.last_byte),
                                  32'(want.last_byte));
               end
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // long receiver hold-off, so the block backs up into req
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_request) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL scaled_command_frame_builder");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------

   // one apb transfer: setup cycle, then access until pready
   task automatic csr_access(input logic write_en, input reg_index_type idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write_en;
      csr_paddr   <= CSR_ADDR_W'(int'(idx) * 4);
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // write all four registers, then read them back
   task automatic apply_settings(input logic [31:0] servo_gain, input logic [31:0] servo_offset,
                                 input logic [31:0] step_gain, input logic [31:0] step_offset);
      logic [31:0] wanted [4];
      logic [31:0] readback;
      wanted[REG_SERVO_GAIN]   = servo_gain;
      wanted[REG_SERVO_OFFSET] = servo_offset;
      wanted[REG_STEP_GAIN]    = step_gain;
      wanted[REG_STEP_OFFSET]  = step_offset;
      foreach (wanted[r]) begin
         csr_access(1'b1, reg_index_type'(r), wanted[r], readback);
         csr_shadow[r] = wanted[r];
      end
      foreach (wanted[r]) begin
         csr_access(1'b0, reg_index_type'(r), '0, readback);
         if (readback !== wanted[r]) begin
            report_mismatch("register readback", readback, wanted[r]);
         end
      end
      @(negedge clock);
   endtask

   task automatic queue_cmd(input logic [15:0] servo, input logic [15:0] step,
                            input logic [7:0] buttons);
      req_type cmd;
      cmd.servo_value  = servo;
      cmd.step_value   = step;
      cmd.button_state = buttons;
      cmd_backlog.push_back(cmd);
   endtask

   // full range half the time, else a small value up to 600 or one near either end
   function automatic logic [15:0] pick_value();
      case ($urandom_range(3))
         0:       return 16'($urandom_range(600));
         1:       return $urandom_range(1) ? 16'hFFFF - 16'($urandom_range(3))
                                           : 16'($urandom_range(3));
         default: return 16'($urandom_range(16'hFFFF));
      endcase
   endfunction

   task automatic queue_random(input int count);
      for (int n = 0; n < count; n++) begin
         queue_cmd(pick_value(), pick_value(), 8'($urandom_range(255)));
      end
   endtask

   // gains around 1/256 spread a full-range value over the byte
   function automatic logic [31:0] rand_gain();
      case ($urandom_range(4))
         0:       return $urandom;
         1:       return 32'($urandom_range(32'h0002_0000)) - 32'h0000_8000;
         default: return 32'($urandom_range(32'h800)) - 32'h100;
      endcase
   endfunction

   function automatic logic [31:0] rand_offset();
      case ($urandom_range(2))
         0:       return $urandom;
         default: return 32'($urandom_range(32'h0140_0000)) - 32'h0020_0000;
      endcase
   endfunction

   // let every command go out and every frame come back
   task automatic finish_phase();
      while (cmd_backlog.size() != 0 || req_valid) begin
         @(negedge clock);
      end
      while (frame_bytes_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values: unity gain, zero offset
      queue_cmd(16'd0,     16'd0,     8'h00);
      queue_cmd(16'd255,   16'd255,   8'hFF);
      queue_cmd(16'd256,   16'd1,     8'hA5);
      queue_cmd(16'hFFFF,  16'hFFFF,  8'h5A);
      queue_cmd(16'd1,     16'd254,   8'h01);
      queue_cmd(16'h8000,  16'h7FFF,  8'h80);
      queue_random(60);
      finish_phase();

      // extreme registers: sums just below zero and far above 255
      apply_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_cmd(16'd0,     16'd0,     8'h3C);
      queue_cmd(16'd1,     16'd1,     8'hC3);
      queue_cmd(16'd2,     16'hFFFF,  8'h0F);
      queue_cmd(16'hFFFF,  16'd2,     8'hF0);
      queue_random(40);
      finish_phase();

      // fractional gains: positive sums under one truncate to zero
      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_settings(32'h0000_0100, 32'h0, 32'h0000_0080, 32'h0000_8000);
      queue_cmd(16'd255,   16'd255,   8'h11);
      queue_cmd(16'd256,   16'd256,   8'h22);
      queue_cmd(16'hFFFF,  16'd0,     8'h44);
      queue_cmd(16'hFF00,  16'd511,   8'h88);
      queue_cmd(16'd0,     16'hFFFF,  8'h7E);
      queue_cmd(16'd257,   16'd512,   8'hE7);
      queue_random(80);
      finish_phase();
      send_idle_pct = IDLE_PCT;
      recv_idle_pct = IDLE_PCT;

      // negative gain, receiver held off while commands keep coming
      apply_settings(32'hFFFF_0000, 32'h00FF_8000, 32'h0000_0400, 32'hFFFF_0000);
      queue_random(60);
      hold_request = 1'b1;
      @(negedge clock);
      hold_request = 1'b0;
      finish_phase();

      // the other corner of the register range
      apply_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_random(30);
      finish_phase();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         apply_settings(rand_gain(), rand_offset(), rand_gain(), rand_offset());
         queue_random(60);
         finish_phase();
      end

      if (error_count == 0) begin
         $display("PASS scaled_command_frame_builder");
      end else begin
         $display("FAIL scaled_command_frame_builder");
      end
      $finish;
   end

endmodule
